// File: hw/rtl/lers_pkg.sv
// ----------------------------------------------------------------------------
// lers_pkg
// Shared widths, reset values, register indexes and row search types for
// the lane edge row search unit.
// ----------------------------------------------------------------------------
package lers_pkg;

	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int WIDTH_W = 11;
	localparam int HGT_W   = 10;
	localparam int OFS_W   = 10;
	localparam int MID_W   = 11;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 11;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 512;

	localparam logic [WIDTH_W-1:0] RST_ROI_WIDTH  = WIDTH_W'(620);
	localparam logic [HGT_W-1:0]   RST_ROI_HEIGHT = HGT_W'(100);
	localparam logic [OFS_W-1:0]   RST_ROI_OFFSET = OFS_W'(9);
	localparam logic [COL_W-1:0]   RST_START      = COL_W'(310);

	typedef enum logic [IDX_W-1:0] {
		REG_ROI_WIDTH  = 2'd0,
		REG_ROI_HEIGHT = 2'd1,
		REG_ROI_OFFSET = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_PIXEL    = 1'b0,
		OP_RECENTER = 1'b1
	} opcode_t;

	// per-row control from the input stage
	typedef struct packed {
		logic             go;        // stage-1 request is consumed this cycle
		logic             hit;       // dark in-range pixel on this row
		logic             last;      // pixel request that closes the frame
		logic             recenter;
		logic [COL_W-1:0] col;
	} row_ctl_t;

	// resolved edges of one row, including the pixel being consumed
	typedef struct packed {
		logic [COL_W-1:0]   left;
		logic [WIDTH_W-1:0] right;   // fallback W-1 is kept unmasked
		logic               left_seen;
		logic               right_seen;
		logic [WIDTH_W-1:0] half;    // floor((left + right) / 2)
	} row_res_t;

endpackage

// File: hw/rtl/lane_edge_row_search_unit.sv
// ----------------------------------------------------------------------------
// lane_edge_row_search_unit
// Lane edge search on the top and bottom rows of a binary region of interest.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless stalled; edge tracking settles in stage 1.
// Result path: a frame-last pixel's result passes stage 2, stage 3 and the output register
//   (edge/start update into stage 2, offset add into stage 3, overall midpoint into output).
// Up to three results queue behind a stalled output before input stalls.
// Reset: asynchronous; registers return to default ROI, both start columns 310.
module lane_edge_row_search_unit #(
	parameter int MAX_WIDTH  = lers_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lers_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [lers_pkg::IDX_W-1:0]   wr_index,
	input  logic [lers_pkg::DATA_W-1:0]  wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [lers_pkg::COL_W-1:0]   column,
	input  logic [lers_pkg::ROW_W-1:0]   row,
	input  logic                         pixel_dark,
	input  logic                         frame_last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lers_pkg::COL_W-1:0]   left_top,
	output logic [lers_pkg::COL_W-1:0]   right_top,
	output logic [lers_pkg::COL_W-1:0]   left_bottom,
	output logic [lers_pkg::COL_W-1:0]   right_bottom,
	output logic                         top_left_seen,
	output logic                         top_right_seen,
	output logic                         bottom_left_seen,
	output logic                         bottom_right_seen,
	output logic [lers_pkg::MID_W-1:0]   middle_top,
	output logic [lers_pkg::MID_W-1:0]   middle_bottom,
	output logic [lers_pkg::MID_W-1:0]   middle_overall
);
	import lers_pkg::*;

	localparam int SUM_W = WIDTH_W + 1;

	// configuration
	logic [WIDTH_W-1:0] roi_width_q;
	logic [HGT_W-1:0]   roi_height_q;
	logic [OFS_W-1:0]   roi_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_width_q  <= RST_ROI_WIDTH;
			roi_height_q <= RST_ROI_HEIGHT;
			roi_offset_q <= RST_ROI_OFFSET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROI_WIDTH:  roi_width_q  <= wr_data;
				REG_ROI_HEIGHT: roi_height_q <= wr_data[HGT_W-1:0];
				REG_ROI_OFFSET: roi_offset_q <= wr_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [WIDTH_W-1:0] w_eff;
	logic [WIDTH_W-1:0] w_m1;
	logic [HGT_W-1:0]   h_eff;
	logic [HGT_W-1:0]   bottom_row;

	always_comb begin
		if (int'(roi_width_q) > MAX_WIDTH)
			w_eff = WIDTH_W'(MAX_WIDTH);
		else if (roi_width_q < WIDTH_W'(2))
			w_eff = WIDTH_W'(2);
		else
			w_eff = roi_width_q;
		if (int'(roi_height_q) > MAX_HEIGHT)
			h_eff = HGT_W'(MAX_HEIGHT);
		else if (roi_height_q < HGT_W'(3))
			h_eff = HGT_W'(3);
		else
			h_eff = roi_height_q;
		w_m1       = w_eff - WIDTH_W'(1);
		bottom_row = h_eff - HGT_W'(2);
	end

	// stage 1: input register
	logic             v_s1;
	opcode_t          op_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             dark_s1;
	logic             last_s1;

	// result pipeline, frame-last requests only
	logic               v_s2;
	logic [COL_W-1:0]   lt_s2, rt_s2, lb_s2, rb_s2;
	logic [3:0]         seen_s2;
	logic [WIDTH_W-1:0] half_t_s2, half_b_s2;

	logic               v_s3;
	logic [COL_W-1:0]   lt_s3, rt_s3, lb_s3, rb_s3;
	logic [3:0]         seen_s3;
	logic [SUM_W-1:0]   mt_s3, mb_s3;

	logic               out_valid_q;
	logic [COL_W-1:0]   lt_q, rt_q, lb_q, rb_q;
	logic [3:0]         seen_q;
	logic [MID_W-1:0]   mt_q, mb_q, mo_q;

	logic out_free, s3_free, s2_free, res_s1, go_s1;

	assign out_free = !out_valid_q || !out_stall;
	assign s3_free  = !v_s3 || out_free;
	assign s2_free  = !v_s2 || s3_free;
	assign res_s1   = (op_s1 == OP_PIXEL) && last_s1;
	assign go_s1    = v_s1 && (!res_s1 || s2_free);
	assign in_stall = v_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1   <= opcode_t'(opcode);
			col_s1  <= column;
			row_s1  <= row;
			dark_s1 <= pixel_dark;
			last_s1 <= frame_last;
		end
	end

	// row searches
	row_ctl_t ctl_top, ctl_bot;
	row_res_t res_top, res_bot;
	logic     pix_ok;

	assign pix_ok = (op_s1 == OP_PIXEL) && dark_s1 && ({1'b0, col_s1} < w_eff);

	always_comb begin
		ctl_top.go       = go_s1;
		ctl_top.hit      = pix_ok && (row_s1 == ROW_W'(1));
		ctl_top.last     = res_s1;
		ctl_top.recenter = (op_s1 == OP_RECENTER);
		ctl_top.col      = col_s1;
		ctl_bot          = ctl_top;
		// a height of 3 puts both searches on row 1
		ctl_bot.hit      = pix_ok && ({1'b0, row_s1} == bottom_row);
	end

	lers_row_search u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_top),
		.half_w (w_eff[COL_W:1]),
		.w_m1   (w_m1),
		.res    (res_top)
	);

	lers_row_search u_bot (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_bot),
		.half_w (w_eff[COL_W:1]),
		.w_m1   (w_m1),
		.res    (res_bot)
	);

	// stage 2: edges and row midpoints; the region offset is added into stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= go_s1 && res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && go_s1 && res_s1) begin
			lt_s2     <= res_top.left;
			rt_s2     <= res_top.right[COL_W-1:0];
			lb_s2     <= res_bot.left;
			rb_s2     <= res_bot.right[COL_W-1:0];
			seen_s2   <= {res_bot.right_seen, res_bot.left_seen,
				res_top.right_seen, res_top.left_seen};
			half_t_s2 <= res_top.half;
			half_b_s2 <= res_bot.half;
		end
	end

	// stage 3: row midpoints plus region offset; the overall midpoint is formed from them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && v_s2) begin
			lt_s3   <= lt_s2;
			rt_s3   <= rt_s2;
			lb_s3   <= lb_s2;
			rb_s3   <= rb_s2;
			seen_s3 <= seen_s2;
			mt_s3   <= SUM_W'(roi_offset_q) + SUM_W'(half_t_s2);
			mb_s3   <= SUM_W'(roi_offset_q) + SUM_W'(half_b_s2);
		end
	end

	logic [SUM_W:0] mo_sum;
	assign mo_sum = {1'b0, mt_s3} + {1'b0, mb_s3};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s3) begin
			lt_q   <= lt_s3;
			rt_q   <= rt_s3;
			lb_q   <= lb_s3;
			rb_q   <= rb_s3;
			seen_q <= seen_s3;
			mt_q   <= mt_s3[MID_W-1:0];
			mb_q   <= mb_s3[MID_W-1:0];
			mo_q   <= mo_sum[MID_W:1];
		end
	end

	assign out_valid         = out_valid_q;
	assign left_top          = lt_q;
	assign right_top         = rt_q;
	assign left_bottom       = lb_q;
	assign right_bottom      = rb_q;
	assign top_left_seen     = seen_q[0];
	assign top_right_seen    = seen_q[1];
	assign bottom_left_seen  = seen_q[2];
	assign bottom_right_seen = seen_q[3];
	assign middle_top        = mt_q;
	assign middle_bottom     = mb_q;
	assign middle_overall    = mo_q;

	// input only backs up when every result slot is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && res_s1 && v_s2 && v_s3 && out_valid_q && out_stall)
		else $error("input stalled with a free result slot");

	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_stall && !v_s3 |=> !out_valid_q)
		else $error("result repeated after it was taken");

	a_left_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !top_left_seen |-> left_top == '0)
		else $error("missing top left edge not reported as column 0");

endmodule

// File: hw/rtl/lers_row_search.sv
// ----------------------------------------------------------------------------
// lers_row_search
// Edge tracker for one searched row: start column, nearest dark pixel on
// each side of it, and their seen flags.
// ----------------------------------------------------------------------------
module lers_row_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lers_pkg::row_ctl_t          ctl,
	input  logic [lers_pkg::COL_W-1:0]  half_w,
	input  logic [lers_pkg::WIDTH_W-1:0] w_m1,
	output lers_pkg::row_res_t          res
);
	import lers_pkg::*;

	logic [COL_W-1:0] start_q;
	logic [COL_W-1:0] left_q;
	logic [COL_W-1:0] right_q;
	logic             left_seen_q;
	logic             right_seen_q;

	logic             left_hit;
	logic             right_hit;
	logic [COL_W-1:0] left_n;
	logic [COL_W-1:0] right_n;
	logic             left_seen_n;
	logic             right_seen_n;
	logic [WIDTH_W:0] sum;

	assign left_hit  = ctl.go && ctl.hit && (ctl.col <= start_q);
	// first dark pixel at or right of start wins
	assign right_hit = ctl.go && ctl.hit && (ctl.col >= start_q) && !right_seen_q;

	assign left_n       = left_hit ? ctl.col : left_q;
	assign right_n      = right_hit ? ctl.col : right_q;
	assign left_seen_n  = left_seen_q || left_hit;
	assign right_seen_n = right_seen_q || right_hit;

	always_comb begin
		res.left       = left_seen_n ? left_n : '0;
		res.right      = right_seen_n ? {1'b0, right_n} : w_m1;
		res.left_seen  = left_seen_n;
		res.right_seen = right_seen_n;
		sum            = {2'b00, res.left} + {1'b0, res.right};
		res.half       = sum[WIDTH_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= RST_START;
			left_q       <= '0;
			right_q      <= '0;
			left_seen_q  <= 1'b0;
			right_seen_q <= 1'b0;
		end else if (ctl.go) begin
			if (ctl.recenter) begin
				start_q <= half_w;
			end else begin
				left_q  <= left_n;
				right_q <= right_n;
				if (ctl.last) begin
					start_q      <= res.half[COL_W-1:0];
					left_seen_q  <= 1'b0;
					right_seen_q <= 1'b0;
				end else begin
					left_seen_q  <= left_seen_n;
					right_seen_q <= right_seen_n;
				end
			end
		end
	end

	a_flags_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.go && ctl.last && !ctl.recenter |=> !left_seen_q && !right_seen_q)
		else $error("seen flags not cleared at frame end");

	a_recentre: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.go && ctl.last && !ctl.recenter |=> start_q == $past(res.half[COL_W-1:0]))
		else $error("start column not moved between edges");

	a_recenter: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.go && ctl.recenter |=> start_q == $past(half_w) &&
			left_seen_q == $past(left_seen_q) && right_seen_q == $past(right_seen_q))
		else $error("recenter request disturbed row state");

endmodule
